// ----- rtl/tcc_pkg.sv -----
// Shared types and constants of the text console cursor engine.
// Holds the command codes, the character codes and the controller/datapath interface structs.
// No dependencies.
package tcc_pkg;

    // Item command codes.
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Control characters and the fill character.
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BLANK = 8'h20;

    // Attribute after reset.
    localparam logic [7:0] COLOR_RESET = 8'h0F;

    // Cursor update requests.
    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_ADVANCE,
        CUR_NEWLINE,
        CUR_CR,
        CUR_BACK,
        CUR_HOME
    } t_cur_op;

    // Screen memory write requests.
    typedef enum logic [2:0] {
        WR_NONE,
        WR_CURSOR_CHAR,
        WR_CURSOR_BLANK,
        WR_CLEAR,
        WR_BLANK_ROW
    } t_wr_op;

    // Screen memory read requests.
    typedef enum logic [1:0] {
        RD_NONE,
        RD_CELL,
        RD_COPY
    } t_rd_op;

    // Sweep counter requests.
    typedef enum logic [1:0] {
        SW_HOLD,
        SW_ORIGIN,
        SW_ROW1,
        SW_STEP
    } t_sw_op;

    typedef struct packed {
        logic    load_in;
        t_cur_op cur_op;
        t_wr_op  wr_op;
        t_rd_op  rd_op;
        t_sw_op  sw_op;
        logic    out_load;
        logic    out_cell;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] cmd;
        logic       is_lf;
        logic       is_cr;
        logic       is_tab;
        logic       is_bs;
        logic       rd_in_range;
        logic       col_last;
        logic       row_last;
        logic       tab_stop;
        logic       sw_end;
        logic       sw_col_last;
    } t_dp_stat;

endpackage

// ----- rtl/tcc_dp.sv -----
// Datapath of the text console cursor engine: input latch, cursor, attribute,
// screen memory with sweep counter, and result register. Depends on tcc_pkg.
module tcc_dp #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tcc_pkg::t_dp_cmd  i_cmd,
    output tcc_pkg::t_dp_stat o_stat,
    input  logic [1:0]        i_command,
    input  logic [7:0]        i_char_code,
    input  logic [4:0]        i_read_row,
    input  logic [6:0]        i_read_col,
    input  logic              i_cfg_valid,
    input  logic [7:0]        i_text_color,
    output logic [4:0]        o_cursor_row,
    output logic [6:0]        o_cursor_col,
    output logic [7:0]        o_cell_char,
    output logic [7:0]        o_cell_color
);

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLS);
    localparam int AW    = RW + CW;
    localparam int DEPTH = 1 << AW;

    localparam logic [RW-1:0] ROW_LAST = RW'(ROWS - 1);
    localparam logic [CW-1:0] COL_LAST = CW'(COLS - 1);

    // Latched item.
    logic [1:0] r_cmd;
    logic [7:0] r_ch;
    logic [4:0] r_rr;
    logic [6:0] r_rc;

    logic [7:0]    r_color;
    logic [RW-1:0] r_row, n_row;
    logic [CW-1:0] r_col, n_col;

    logic [RW-1:0] r_sw_row, n_sw_row;
    logic [CW-1:0] r_sw_col, n_sw_col;

    // Copy write-back stage of a scroll.
    logic          r_wb_vld;
    logic [RW-1:0] r_wb_row;
    logic [CW-1:0] r_wb_col;

    logic [15:0] mem [DEPTH];
    logic [15:0] r_rd_q;

    logic          we;
    logic [AW-1:0] wa;
    logic [15:0]   wd;
    logic          re;
    logic [AW-1:0] ra;

    logic [4:0] r_o_row;
    logic [6:0] r_o_col;
    logic [7:0] r_o_char;
    logic [7:0] r_o_color;

    logic col_last, row_last;

    assign col_last = (r_col == COL_LAST);
    assign row_last = (r_row == ROW_LAST);

    always_comb begin
        o_stat.cmd         = r_cmd;
        o_stat.is_lf       = (r_ch == tcc_pkg::CH_LF);
        o_stat.is_cr       = (r_ch == tcc_pkg::CH_CR);
        o_stat.is_tab      = (r_ch == tcc_pkg::CH_TAB);
        o_stat.is_bs       = (r_ch == tcc_pkg::CH_BS);
        o_stat.rd_in_range = ({2'b00, r_rr} < 7'(ROWS)) && ({1'b0, r_rc} < 8'(COLS));
        o_stat.col_last    = col_last;
        o_stat.row_last    = row_last;
        o_stat.tab_stop    = (r_col[2:0] == 3'b111);
        o_stat.sw_end      = (r_sw_row == ROW_LAST) && (r_sw_col == COL_LAST);
        o_stat.sw_col_last = (r_sw_col == COL_LAST);
    end

    // Cursor update.
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        case (i_cmd.cur_op)
            tcc_pkg::CUR_ADVANCE: begin
                if (col_last) begin
                    n_col = '0;
                    if (!row_last) begin
                        n_row = r_row + 1'b1;
                    end
                end else begin
                    n_col = r_col + 1'b1;
                end
            end
            tcc_pkg::CUR_NEWLINE: begin
                n_col = '0;
                if (!row_last) begin
                    n_row = r_row + 1'b1;
                end
            end
            tcc_pkg::CUR_CR: begin
                n_col = '0;
            end
            tcc_pkg::CUR_BACK: begin
                if (r_col != '0) begin
                    n_col = r_col - 1'b1;
                end else if (r_row != '0) begin
                    n_row = r_row - 1'b1;
                    n_col = COL_LAST;
                end
            end
            tcc_pkg::CUR_HOME: begin
                n_row = '0;
                n_col = '0;
            end
            default: begin
            end
        endcase
    end

    // Sweep counter over the screen in row-major order.
    always_comb begin
        n_sw_row = r_sw_row;
        n_sw_col = r_sw_col;
        case (i_cmd.sw_op)
            tcc_pkg::SW_ORIGIN: begin
                n_sw_row = '0;
                n_sw_col = '0;
            end
            tcc_pkg::SW_ROW1: begin
                n_sw_row = RW'(1);
                n_sw_col = '0;
            end
            tcc_pkg::SW_STEP: begin
                if (r_sw_col == COL_LAST) begin
                    n_sw_col = '0;
                    n_sw_row = r_sw_row + 1'b1;
                end else begin
                    n_sw_col = r_sw_col + 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Write port: a pending copy write-back never overlaps another write.
    always_comb begin
        we = 1'b0;
        wa = {r_row, r_col};
        wd = {r_color, tcc_pkg::CH_BLANK};
        if (r_wb_vld) begin
            we = 1'b1;
            wa = {r_wb_row - 1'b1, r_wb_col};
            wd = r_rd_q;
        end else begin
            case (i_cmd.wr_op)
                tcc_pkg::WR_CURSOR_CHAR: begin
                    we = 1'b1;
                    wd = {r_color, r_ch};
                end
                tcc_pkg::WR_CURSOR_BLANK: begin
                    we = 1'b1;
                end
                tcc_pkg::WR_CLEAR: begin
                    we = 1'b1;
                    wa = {r_sw_row, r_sw_col};
                end
                tcc_pkg::WR_BLANK_ROW: begin
                    we = 1'b1;
                    wa = {ROW_LAST, r_sw_col};
                end
                default: begin
                end
            endcase
        end
    end

    // Read port.
    always_comb begin
        re = 1'b0;
        ra = {r_sw_row, r_sw_col};
        case (i_cmd.rd_op)
            tcc_pkg::RD_CELL: begin
                re = 1'b1;
                ra = {RW'(r_rr), CW'(r_rc)};
            end
            tcc_pkg::RD_COPY: begin
                re = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        if (re) begin
            r_rd_q <= mem[ra];
        end
    end

    // Control state of the datapath.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_color  <= tcc_pkg::COLOR_RESET;
            r_wb_vld <= 1'b0;
        end else begin
            r_row    <= n_row;
            r_col    <= n_col;
            r_wb_vld <= (i_cmd.rd_op == tcc_pkg::RD_COPY);
            if (i_cfg_valid) begin
                r_color <= i_text_color;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_sw_row <= n_sw_row;
        r_sw_col <= n_sw_col;
        r_wb_row <= r_sw_row;
        r_wb_col <= r_sw_col;
        if (i_cmd.load_in) begin
            r_cmd <= i_command;
            r_ch  <= i_char_code;
            r_rr  <= i_read_row;
            r_rc  <= i_read_col;
        end
        if (i_cmd.out_load) begin
            r_o_row   <= 5'(r_row);
            r_o_col   <= 7'(r_col);
            r_o_char  <= i_cmd.out_cell ? r_rd_q[7:0]  : 8'h00;
            r_o_color <= i_cmd.out_cell ? r_rd_q[15:8] : 8'h00;
        end
    end

    assign o_cursor_row = r_o_row;
    assign o_cursor_col = r_o_col;
    assign o_cell_char  = r_o_char;
    assign o_cell_color = r_o_color;

endmodule

// ----- rtl/tcc_ctrl.sv -----
// Controller of the text console cursor engine: sequences each item and owns the handshakes.
// Depends on tcc_pkg; drives tcc_dp through command and status structs.
module tcc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  tcc_pkg::t_dp_stat i_stat,
    output tcc_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TAB,
        ST_CLEAR,
        ST_COPY,
        ST_DRAIN,
        ST_BLANK,
        ST_FINISH
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_is_read, n_is_read;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        n_is_read   = r_is_read;
        o_in_ready  = 1'b0;
        o_cmd.load_in  = 1'b0;
        o_cmd.cur_op   = tcc_pkg::CUR_HOLD;
        o_cmd.wr_op    = tcc_pkg::WR_NONE;
        o_cmd.rd_op    = tcc_pkg::RD_NONE;
        o_cmd.sw_op    = tcc_pkg::SW_HOLD;
        o_cmd.out_load = 1'b0;
        o_cmd.out_cell = r_is_read;

        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = ST_DECODE;
                end
            end
            ST_DECODE: begin
                n_is_read = 1'b0;
                n_state   = ST_FINISH;
                case (i_stat.cmd)
                    tcc_pkg::CMD_PUT: begin
                        if (i_stat.is_lf) begin
                            o_cmd.cur_op = tcc_pkg::CUR_NEWLINE;
                            if (i_stat.row_last) begin
                                o_cmd.sw_op = tcc_pkg::SW_ROW1;
                                n_state     = ST_COPY;
                            end
                        end else if (i_stat.is_cr) begin
                            o_cmd.cur_op = tcc_pkg::CUR_CR;
                        end else if (i_stat.is_tab) begin
                            n_state = ST_TAB;
                        end else if (i_stat.is_bs) begin
                            o_cmd.cur_op = tcc_pkg::CUR_BACK;
                        end else begin
                            o_cmd.wr_op  = tcc_pkg::WR_CURSOR_CHAR;
                            o_cmd.cur_op = tcc_pkg::CUR_ADVANCE;
                            if (i_stat.col_last && i_stat.row_last) begin
                                o_cmd.sw_op = tcc_pkg::SW_ROW1;
                                n_state     = ST_COPY;
                            end
                        end
                    end
                    tcc_pkg::CMD_CLEAR: begin
                        o_cmd.sw_op = tcc_pkg::SW_ORIGIN;
                        n_state     = ST_CLEAR;
                    end
                    tcc_pkg::CMD_READ: begin
                        if (i_stat.rd_in_range) begin
                            o_cmd.rd_op = tcc_pkg::RD_CELL;
                            n_is_read   = 1'b1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ST_TAB: begin
                o_cmd.wr_op  = tcc_pkg::WR_CURSOR_BLANK;
                o_cmd.cur_op = tcc_pkg::CUR_ADVANCE;
                if (i_stat.col_last) begin
                    if (i_stat.row_last) begin
                        o_cmd.sw_op = tcc_pkg::SW_ROW1;
                        n_state     = ST_COPY;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end else if (i_stat.tab_stop) begin
                    n_state = ST_FINISH;
                end
            end
            ST_CLEAR: begin
                o_cmd.wr_op = tcc_pkg::WR_CLEAR;
                o_cmd.sw_op = tcc_pkg::SW_STEP;
                if (i_stat.sw_end) begin
                    o_cmd.cur_op = tcc_pkg::CUR_HOME;
                    n_state      = ST_FINISH;
                end
            end
            ST_COPY: begin
                o_cmd.rd_op = tcc_pkg::RD_COPY;
                o_cmd.sw_op = tcc_pkg::SW_STEP;
                if (i_stat.sw_end) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // The last copied cell is written back in this cycle.
                o_cmd.sw_op = tcc_pkg::SW_ORIGIN;
                n_state     = ST_BLANK;
            end
            ST_BLANK: begin
                o_cmd.wr_op = tcc_pkg::WR_BLANK_ROW;
                o_cmd.sw_op = tcc_pkg::SW_STEP;
                if (i_stat.sw_col_last) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_is_read   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_is_read   <= n_is_read;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/text_console_cursor_engine.sv -----
// Text console cursor engine, top level.
// Depends on tcc_pkg, tcc_ctrl and tcc_dp.
//
// The block keeps a ROWS x COLS screen of 16-bit cells (character in the low byte,
// attribute in the high byte) and a cursor. Every input transfer carries one command
// and yields exactly one result transfer holding the cursor after the command and,
// for an in-range cell read, the cell contents (zero otherwise). Command 0 puts a byte:
// line feed, carriage return, tab (blanks up to the next column that is a multiple of 8,
// at least one) and backspace (moves left, wraps to the previous row, stops at the origin)
// are interpreted, any other byte is stored with the current attribute. Moving below the
// last row scrolls the screen up and blanks the bottom row. Command 1 blanks the screen
// and homes the cursor, command 2 reads one cell, command 3 only reports the cursor.
// The screen memory has a write port and a separate read port and takes one cell write per
// clock. A plain character, control code or read passes through accept, decode and result
// load; a tab writes its blanks (1 to 8) in a tab state before the result load; a clear
// writes every cell in turn. A scroll adds a copy of rows 1 to ROWS-1 up by one row, a
// drain step and a fill of the bottom row with blanks. Screen cells are undefined after
// reset until written by a clear, a put or a scroll. A new input transfer is accepted as
// soon as the previous command has placed its result in the output register, even while
// that result still waits for the consumer. The attribute register (reset value 15) is
// written through the configuration channel, which is always ready; write it only while
// the block is idle.
module text_console_cursor_engine #(
    parameter int ROWS = 25,
    parameter int COLS = 80
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Command channel.
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_command,
    input  logic [7:0] i_char_code,
    input  logic [4:0] i_read_row,
    input  logic [6:0] i_read_col,
    // Result channel.
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [4:0] o_cursor_row,
    output logic [6:0] o_cursor_col,
    output logic [7:0] o_cell_char,
    output logic [7:0] o_cell_color,
    // Attribute register write channel.
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_text_color
);

    tcc_pkg::t_dp_cmd  dp_cmd;
    tcc_pkg::t_dp_stat dp_stat;

    // The attribute register takes a write in any cycle.
    assign o_cfg_ready = 1'b1;

    tcc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (dp_stat),
        .o_cmd       (dp_cmd)
    );

    tcc_dp #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .i_command    (i_command),
        .i_char_code  (i_char_code),
        .i_read_row   (i_read_row),
        .i_read_col   (i_read_col),
        .i_cfg_valid  (i_cfg_valid),
        .i_text_color (i_text_color),
        .o_cursor_row (o_cursor_row),
        .o_cursor_col (o_cursor_col),
        .o_cell_char  (o_cell_char),
        .o_cell_color (o_cell_color)
    );

endmodule

// ----- tb/text_console_cursor_engine_tb.sv -----
// Self-checking testbench for the text console cursor engine.
// Depends on tcc_pkg and text_console_cursor_engine; predicts every result in-line.
// Runs directed clear, cursor, read and attribute cases, then random traffic with scrolls, mostly with random stalls.
module text_console_cursor_engine_tb;

    localparam int ROWS = 25;
    localparam int COLS = 80;
    localparam int TAB_STOP = 8;
    // The unused command leaves everything as it is and only reports the cursor.
    localparam logic [1:0] CMD_NOP = 2'd3;
    // Cycles to let pass once the last result has arrived, before a register write
    // or the end of the run.
    localparam int IDLE_SETTLE = 8;
    // About 830 items, each at worst a full-screen pass plus a random gap on both sides,
    // fit well within the limit, which leaves a wide margin.
    localparam int LIMIT_CYCLES = 10_000_000;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [4:0] row;
        logic [6:0] col;
        logic [7:0] cell_char;
        logic [7:0] cell_color;
    } t_cursor_report;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_ready;
    logic [1:0] i_command = tcc_pkg::CMD_PUT;
    logic [7:0] i_char_code = 8'h00;
    logic [4:0] i_read_row = 5'd0;
    logic [6:0] i_read_col = 7'd0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    logic [4:0] o_cursor_row;
    logic [6:0] o_cursor_col;
    logic [7:0] o_cell_char;
    logic [7:0] o_cell_color;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_text_color = tcc_pkg::COLOR_RESET;

    text_console_cursor_engine #(
        .ROWS(ROWS),
        .COLS(COLS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .i_char_code (i_char_code),
        .i_read_row  (i_read_row),
        .i_read_col  (i_read_col),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cursor_row(o_cursor_row),
        .o_cursor_col(o_cursor_col),
        .o_cell_char (o_cell_char),
        .o_cell_color(o_cell_color),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_text_color(i_text_color)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Console predictor: a shadow of the screen, the cursor and the attribute.
    // ------------------------------------------------------------------
    logic [15:0] screen_shadow [ROWS*COLS];
    int unsigned cursor_row_shadow = 0;
    int unsigned cursor_col_shadow = 0;
    logic [7:0]  attr_shadow = tcc_pkg::COLOR_RESET;
    // Cells hold nothing defined until the first clear, so reads of real cells
    // are only issued once a clear has been predicted.
    bit          screen_cleared = 1'b0;

    // Expected results, oldest first, pushed when an input transfer happens.
    t_cursor_report pending_reports [$];

    bit stall_enable = 1'b1;
    int mismatch_count = 0;
    int cycle_count = 0;

    function automatic void store_cell(int unsigned r, int unsigned c, logic [7:0] ch);
        if (r < ROWS && c < COLS)
            screen_shadow[r*COLS + c] = {attr_shadow, ch};
    endfunction

    function automatic void scroll_screen();
        for (int i = 0; i < (ROWS-1)*COLS; i++)
            screen_shadow[i] = screen_shadow[i + COLS];
        for (int c = 0; c < COLS; c++)
            store_cell(ROWS-1, c, tcc_pkg::CH_BLANK);
    endfunction

    function automatic void line_down();
        cursor_row_shadow++;
        if (cursor_row_shadow >= ROWS) begin
            scroll_screen();
            cursor_row_shadow = ROWS - 1;
        end
    endfunction

    function automatic void step_column();
        cursor_col_shadow++;
        if (cursor_col_shadow >= COLS) begin
            cursor_col_shadow = 0;
            line_down();
        end
    endfunction

    function automatic void put_byte(logic [7:0] ch);
        if (ch == tcc_pkg::CH_LF) begin
            cursor_col_shadow = 0;
            line_down();
        end else if (ch == tcc_pkg::CH_CR) begin
            cursor_col_shadow = 0;
        end else if (ch == tcc_pkg::CH_TAB) begin
            // A tab always writes at least one blank.
            do begin
                store_cell(cursor_row_shadow, cursor_col_shadow, tcc_pkg::CH_BLANK);
                step_column();
            end while (cursor_col_shadow % TAB_STOP != 0);
        end else if (ch == tcc_pkg::CH_BS) begin
            // Backspace erases nothing and stops at the origin.
            if (cursor_col_shadow > 0) begin
                cursor_col_shadow--;
            end else if (cursor_row_shadow > 0) begin
                cursor_row_shadow--;
                cursor_col_shadow = COLS - 1;
            end
        end else begin
            store_cell(cursor_row_shadow, cursor_col_shadow, ch);
            step_column();
        end
    endfunction

    function automatic t_cursor_report predict_console(logic [1:0] cmd, logic [7:0] ch,
                                                       logic [4:0] rr, logic [6:0] rc);
        t_cursor_report rep;
        logic [15:0]    read_word;
        read_word = 16'h0000;
        case (cmd)
            tcc_pkg::CMD_PUT: begin
                put_byte(ch);
            end
            tcc_pkg::CMD_CLEAR: begin
                for (int r = 0; r < ROWS; r++)
                    for (int c = 0; c < COLS; c++)
                        store_cell(r, c, tcc_pkg::CH_BLANK);
                cursor_row_shadow = 0;
                cursor_col_shadow = 0;
                screen_cleared = 1'b1;
            end
            tcc_pkg::CMD_READ: begin
                // Out-of-range coordinates touch no cell and return zero.
                if (rr < ROWS && rc < COLS)
                    read_word = screen_shadow[rr*COLS + rc];
            end
            default: begin
            end
        endcase
        rep.row        = cursor_row_shadow[4:0];
        rep.col        = cursor_col_shadow[6:0];
        rep.cell_char  = read_word[7:0];
        rep.cell_color = read_word[15:8];
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus side of the command channel.
    // ------------------------------------------------------------------

    // Sends one command. The gap before it is drawn here, so valid is only lowered
    // when a gap follows and is never dropped and raised in the same step.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] ch,
                             input logic [4:0] rr, input logic [6:0] rc);
        int gap;
        gap = stall_enable ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command   <= cmd;
        i_char_code <= ch;
        i_read_row  <= rr;
        i_read_col  <= rc;
        do @(posedge i_clk); while (!o_in_ready);
        pending_reports.push_back(predict_console(cmd, ch, rr, rc));
    endtask

    // Put a character; the unused read coordinates carry random bits.
    task automatic put_char(input logic [7:0] ch);
        send_item(tcc_pkg::CMD_PUT, ch, 5'($urandom), 7'($urandom));
    endtask

    task automatic read_cell(input logic [4:0] rr, input logic [6:0] rc);
        send_item(tcc_pkg::CMD_READ, 8'($urandom), rr, rc);
    endtask

    task automatic clear_screen();
        send_item(tcc_pkg::CMD_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
    endtask

    // Stops sending, lets every outstanding result arrive and the block settle.
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0) @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    // Writes the attribute register, only ever from an idle block.
    task automatic write_color(input logic [7:0] color);
        wait_idle();
        i_cfg_valid  <= 1'b1;
        i_text_color <= color;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid  <= 1'b0;
        attr_shadow = color;
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls on ready, one draw per result transfer.
    // ------------------------------------------------------------------
    initial begin
        int gap;
        forever begin
            gap = stall_enable ? $urandom_range(0, 9) : 0;
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Every result transfer is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_cursor_report want;
        t_cursor_report got;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = '{o_cursor_row, o_cursor_col, o_cell_char, o_cell_color};
            if (pending_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_SHOWN)
                    $display("unexpected result: row %0d col %0d char %h color %h",
                             got.row, got.col, got.cell_char, got.cell_color);
            end else begin
                want = pending_reports.pop_front();
                if (got.row !== want.row || got.col !== want.col ||
                    got.cell_char !== want.cell_char ||
                    got.cell_color !== want.cell_color) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                        $display("mismatch: expected row %0d col %0d char %h color %h, %s",
                                 want.row, want.col, want.cell_char, want.cell_color,
                                 $sformatf("got row %0d col %0d char %h color %h",
                                           got.row, got.col, got.cell_char,
                                           got.cell_color));
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Directed tests.
    // ------------------------------------------------------------------

    // A clear fills every cell with blanks in the reset attribute and homes the cursor.
    task automatic test_clear_home();
        clear_screen();
        read_cell(5'd0, 7'd0);
        read_cell(5'(ROWS-1), 7'(COLS-1));
    endtask

    // Ordinary bytes, including the extremes, are stored and advance the cursor.
    task automatic test_plain_bytes();
        put_char(8'h41);
        put_char(8'hFF);
        put_char(8'h00);
        read_cell(5'd0, 7'd1);
    endtask

    // Carriage return, tabs of full and partial width, backspace wrap and line wrap.
    task automatic test_control_codes();
        put_char(tcc_pkg::CH_CR);
        put_char(tcc_pkg::CH_TAB);
        put_char(8'h78);
        put_char(tcc_pkg::CH_TAB);
        put_char(tcc_pkg::CH_BS);
        put_char(tcc_pkg::CH_LF);
        put_char(tcc_pkg::CH_BS);
        put_char(8'h5A);
        clear_screen();
        put_char(tcc_pkg::CH_BS);
    endtask

    // Reads outside the screen return zero, and the unused command only reports
    // the cursor; all-ones coordinates cover the top bits of both fields.
    task automatic test_read_edges();
        read_cell(5'(ROWS), 7'd0);
        read_cell(5'd0, 7'(COLS));
        read_cell(5'h1F, 7'h7F);
        send_item(CMD_NOP, 8'($urandom), 5'($urandom), 7'($urandom));
    endtask

    // Both attribute extremes reach written characters and the blank fill.
    task automatic test_color_extremes();
        write_color(8'h00);
        put_char(8'h2A);
        read_cell(5'd0, 7'd0);
        write_color(8'hFF);
        clear_screen();
        read_cell(5'd3, 7'd40);
    endtask

    // ------------------------------------------------------------------
    // Random traffic.
    // ------------------------------------------------------------------
    function automatic logic [7:0] pick_char(bit lf_heavy);
        int roll;
        int lf_pct;
        roll   = $urandom_range(0, 99);
        lf_pct = lf_heavy ? 30 : 6;
        if (roll < lf_pct)           return tcc_pkg::CH_LF;
        else if (roll < lf_pct + 4)  return tcc_pkg::CH_CR;
        else if (roll < lf_pct + 9)  return tcc_pkg::CH_TAB;
        else if (roll < lf_pct + 15) return tcc_pkg::CH_BS;
        else                         return 8'($urandom);
    endfunction

    // One phase of random commands at a given attribute. Mostly puts, with reads
    // of real cells, a few reads anywhere in the field range, rare clears and
    // the odd unused command. The line-feed-heavy flavor keeps the cursor on the
    // bottom row so that scrolls come often.
    task automatic test_random_phase(input int count, input logic [7:0] color,
                                     input bit lf_heavy, input bit stalls);
        int roll;
        write_color(color);
        stall_enable = stalls;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 1) begin
                clear_screen();
            end else if (roll < 4) begin
                send_item(CMD_NOP, 8'($urandom), 5'($urandom), 7'($urandom));
            end else if (roll < 22) begin
                if (!screen_cleared || $urandom_range(0, 4) == 0)
                    read_cell(screen_cleared ? 5'($urandom) : 5'(ROWS), 7'($urandom));
                else
                    read_cell(5'($urandom_range(0, ROWS-1)),
                              7'($urandom_range(0, COLS-1)));
            end else begin
                put_char(pick_char(lf_heavy));
            end
        end
        stall_enable = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_clear_home();
        test_plain_bytes();
        test_control_codes();
        test_read_edges();
        test_color_extremes();

        test_random_phase(250, 8'($urandom), 1'b0, 1'b1);
        test_random_phase(150, 8'h00, 1'b0, 1'b0);
        test_random_phase(250, 8'hFF, 1'b1, 1'b1);
        test_random_phase(150, 8'($urandom), 1'b0, 1'b1);

        wait_idle();
        if (mismatch_count == 0 && pending_reports.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
